// ===== rtl/core/mgvfm_pkg.sv =====
package mgvfm_pkg;

  localparam int READING_BITS = 10;
  localparam int COUNT_BITS   = 15;
  localparam int GAIN_BITS    = 8;
  localparam int DIV_BITS     = 16;
  localparam int LIMIT_BITS   = 8;
  localparam int DELAY_BITS   = 8;
  localparam int PROD_BITS    = READING_BITS + GAIN_BITS;
  localparam int WIN_BITS     = 12;
  localparam int ADDR_BITS    = 5;
  localparam int DATA_BITS    = 32;

  localparam logic [COUNT_BITS-1:0] IDLE_MARK = COUNT_BITS'(25500);

  localparam logic [COUNT_BITS-1:0] MAINS_UNSET_COUNT = COUNT_BITS'(400);
  localparam logic [COUNT_BITS-1:0] GEN_UNSET_COUNT   = COUNT_BITS'(500);
  localparam logic [COUNT_BITS-1:0] MAINS_DELAY_SCALE = COUNT_BITS'(100);
  localparam logic [COUNT_BITS-1:0] GEN_DELAY_SCALE   = COUNT_BITS'(25);
  localparam logic [DELAY_BITS-1:0] UNSET_DELAY       = DELAY_BITS'(255);
  localparam logic [WIN_BITS-1:0]   LIMIT_SCALE       = WIN_BITS'(10);

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET    = GAIN_BITS'(215);
  localparam logic [DIV_BITS-1:0]   DIVISOR_RESET = DIV_BITS'(602);
  localparam logic [LIMIT_BITS-1:0] LOW_RESET     = LIMIT_BITS'(100);
  localparam logic [LIMIT_BITS-1:0] HIGH_RESET    = LIMIT_BITS'(240);
  localparam logic [DELAY_BITS-1:0] DELAY_RESET   = DELAY_BITS'(255);

  localparam logic [2:0] REG_GAIN    = 3'd0;
  localparam logic [2:0] REG_DIVISOR = 3'd1;
  localparam logic [2:0] REG_LOW     = 3'd2;
  localparam logic [2:0] REG_HIGH    = 3'd3;
  localparam logic [2:0] REG_DELAY   = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] ACT_BOTH  = 2'd0;
  localparam logic [1:0] ACT_MAINS = 2'd1;
  localparam logic [1:0] ACT_GEN   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic                    op;
    logic [READING_BITS-1:0] generator_reading;
    logic [READING_BITS-1:0] mains_reading_a;
    logic [READING_BITS-1:0] mains_reading_b;
    logic [READING_BITS-1:0] mains_reading_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       mains_out_of_window;
    logic       generator_out_of_window;
  } out_item_t;

endpackage

// ===== rtl/core/mains_generator_voltage_fault_monitor.sv =====
// Mains and generator voltage fault monitor.
// Input channel (in_valid, in_stall, in_data): a transaction is either a
// sample (op clear) with one generator and three mains readings, or a
// timer tick (op set). A tick is taken without a stall, decrements the
// armed countdowns and gives no result. A sample scales each reading by
// gain/divisor, checks it against the voltage window, arms or clears the
// countdowns and gives one result on the output channel (out_valid,
// out_stall, out_data).
// A sample takes, per reading, one load, 18 restoring divide steps and
// one window check, then one more step to post the result; in_stall
// stays high until it is posted. The next transaction is taken in the
// cycle after that, and none while a sample is in progress.
// The result sits in an output register; while the receiver stalls, the
// block still accepts ticks, and a finished sample waits until the
// register frees. Registers are to be written over the APB port only
// while the block is idle; the block itself does not enforce it.
// Synchronous reset restores register defaults, empties the output and
// sets both countdowns to zero (expired, not idle).
module mains_generator_voltage_fault_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mgvfm_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mgvfm_pkg::out_item_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mgvfm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mgvfm_pkg::DATA_BITS-1:0] pwdata,
  output logic [mgvfm_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import mgvfm_pkg::*;

  localparam int STEP_BITS = $clog2(PROD_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PROD_BITS - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_CHK, ST_DONE} state_t;

  state_t                  state;
  logic [GAIN_BITS-1:0]    scale_gain;
  logic [DIV_BITS-1:0]     scale_divisor;
  logic [LIMIT_BITS-1:0]   low_limit;
  logic [LIMIT_BITS-1:0]   high_limit;
  logic [DELAY_BITS-1:0]   fault_delay;
  logic [COUNT_BITS-1:0]   mains_count;
  logic [COUNT_BITS-1:0]   gen_count;
  in_item_t                item;
  logic [1:0]              phase;
  logic [STEP_BITS-1:0]    step;
  logic [PROD_BITS-1:0]    quo;
  logic [DIV_BITS-1:0]     rem;
  logic                    mains_bad;
  logic                    gen_bad;

  logic                    cfg_write;
  logic [2:0]              reg_index;
  logic [READING_BITS-1:0] reading;
  logic [DIV_BITS:0]       rem_shift;
  logic [DIV_BITS:0]       rem_diff;
  logic                    fits;
  logic [WIN_BITS-1:0]     low_win;
  logic [WIN_BITS-1:0]     high_win;
  logic                    reading_bad;
  logic [COUNT_BITS-1:0]   mains_arm;
  logic [COUNT_BITS-1:0]   gen_arm;
  logic [COUNT_BITS-1:0]   mains_tick;
  logic [COUNT_BITS-1:0]   gen_tick;
  logic [COUNT_BITS-1:0]   mains_count_next;
  logic [COUNT_BITS-1:0]   gen_count_next;
  logic [1:0]              action_next;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_gain    <= GAIN_RESET;
      scale_divisor <= DIVISOR_RESET;
      low_limit     <= LOW_RESET;
      high_limit    <= HIGH_RESET;
      fault_delay   <= DELAY_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_GAIN:    scale_gain    <= pwdata[GAIN_BITS-1:0];
        REG_DIVISOR: scale_divisor <= pwdata[DIV_BITS-1:0];
        REG_LOW:     low_limit     <= pwdata[LIMIT_BITS-1:0];
        REG_HIGH:    high_limit    <= pwdata[LIMIT_BITS-1:0];
        REG_DELAY:   fault_delay   <= pwdata[DELAY_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_GAIN:    prdata = DATA_BITS'(scale_gain);
      REG_DIVISOR: prdata = DATA_BITS'(scale_divisor);
      REG_LOW:     prdata = DATA_BITS'(low_limit);
      REG_HIGH:    prdata = DATA_BITS'(high_limit);
      REG_DELAY:   prdata = DATA_BITS'(fault_delay);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    unique case (phase)
      2'd0:    reading = item.generator_reading;
      2'd1:    reading = item.mains_reading_a;
      2'd2:    reading = item.mains_reading_b;
      default: reading = item.mains_reading_c;
    endcase
  end

  // one restoring divide step
  assign rem_shift = {rem, quo[PROD_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, scale_divisor};
  assign fits      = (rem_shift >= {1'b0, scale_divisor});

  assign low_win     = WIN_BITS'(low_limit) * LIMIT_SCALE;
  assign high_win    = WIN_BITS'(high_limit) * LIMIT_SCALE;
  assign reading_bad = (scale_divisor == '0)
                    || (quo < PROD_BITS'(low_win))
                    || (quo > PROD_BITS'(high_win));

  assign mains_arm = (fault_delay == UNSET_DELAY) ? MAINS_UNSET_COUNT
                   : COUNT_BITS'(fault_delay) * MAINS_DELAY_SCALE;
  assign gen_arm   = (fault_delay == UNSET_DELAY) ? GEN_UNSET_COUNT
                   : COUNT_BITS'(fault_delay) * GEN_DELAY_SCALE;

  assign mains_tick = (mains_count != IDLE_MARK && mains_count != '0)
                    ? mains_count - COUNT_BITS'(1) : mains_count;
  assign gen_tick   = (gen_count != IDLE_MARK && gen_count != '0)
                    ? gen_count - COUNT_BITS'(1) : gen_count;

  always_comb begin
    if (!mains_bad) begin
      mains_count_next = IDLE_MARK;
    end else if (mains_count == IDLE_MARK) begin
      mains_count_next = mains_arm;
    end else begin
      mains_count_next = mains_count;
    end
    if (!gen_bad) begin
      gen_count_next = IDLE_MARK;
    end else if (gen_count == IDLE_MARK) begin
      gen_count_next = gen_arm;
    end else begin
      gen_count_next = gen_count;
    end
    priority if (mains_bad && gen_bad && mains_count_next == '0 && gen_count_next == '0) begin
      action_next = ACT_BOTH;
    end else if (mains_bad && mains_count_next == '0) begin
      action_next = ACT_MAINS;
    end else if (gen_bad && gen_count_next == '0) begin
      action_next = ACT_GEN;
    end else begin
      action_next = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      mains_count <= '0;
      gen_count   <= '0;
    end else begin
      out_valid <= (state == ST_DONE) || (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.op == OP_TICK) begin
              mains_count <= mains_tick;
              gen_count   <= gen_tick;
            end else begin
              item      <= in_data;
              phase     <= 2'd0;
              mains_bad <= 1'b0;
              gen_bad   <= 1'b0;
              state     <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          quo   <= PROD_BITS'(reading) * PROD_BITS'(scale_gain);
          rem   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          quo  <= {quo[PROD_BITS-2:0], fits};
          rem  <= fits ? rem_diff[DIV_BITS-1:0] : rem_shift[DIV_BITS-1:0];
          step <= step + STEP_BITS'(1);
          if (step == LAST_STEP) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (phase == 2'd0) begin
            gen_bad <= reading_bad;
          end else begin
            mains_bad <= mains_bad || reading_bad;
          end
          phase <= phase + 2'd1;
          state <= (phase == 2'd3) ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            mains_count                      <= mains_count_next;
            gen_count                        <= gen_count_next;
            out_data.action                  <= action_next;
            out_data.mains_out_of_window     <= mains_bad;
            out_data.generator_out_of_window <= gen_bad;
            state                            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/mgvfm_checker.sv =====
module mgvfm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  mgvfm_pkg::in_item_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mgvfm_pkg::out_item_t          out_data
);
  import mgvfm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == OP_SAMPLE |=> in_stall)
    else $error("sample did not occupy the block");

  a_tick_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == OP_TICK |=> !in_stall)
    else $error("tick did not complete in one cycle");

  a_action_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.action != ACT_BOTH ||
       (out_data.mains_out_of_window && out_data.generator_out_of_window)) &&
      (out_data.action != ACT_MAINS || out_data.mains_out_of_window) &&
      (out_data.action != ACT_GEN || out_data.generator_out_of_window))
    else $error("action disagrees with window flags");

endmodule

bind mains_generator_voltage_fault_monitor mgvfm_checker u_checker (.*);

// ===== tb/sv/mains_generator_voltage_fault_monitor_tb.sv =====
`timescale 1ns / 1ps

module mains_generator_voltage_fault_monitor_tb;
  import mgvfm_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_CYCLES    = 600;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_BITS-1:0]  paddr    = '0;
  logic [DATA_BITS-1:0]  pwdata   = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  logic [GAIN_BITS-1:0]  shadow_gain  = GAIN_RESET;
  logic [DIV_BITS-1:0]   shadow_div   = DIVISOR_RESET;
  logic [LIMIT_BITS-1:0] shadow_low   = LOW_RESET;
  logic [LIMIT_BITS-1:0] shadow_high  = HIGH_RESET;
  logic [DELAY_BITS-1:0] shadow_delay = DELAY_RESET;
  logic [COUNT_BITS-1:0] mains_timer  = '0;
  logic [COUNT_BITS-1:0] gen_timer    = '0;

  out_item_t pending_results[$];
  int mismatch_count = 0;
  int items_sent     = 0;
  int sample_count   = 0;
  int tick_count     = 0;
  int results_seen   = 0;
  int action_seen[4] = '{0, 0, 0, 0};
  int idle_cycles    = 0;
  int rx_hold        = 0;
  int rx_wait        = 0;
  bit pace_on        = 1'b1;

  mains_generator_voltage_fault_monitor i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  function automatic logic [31:0] scale_value(logic [READING_BITS-1:0] raw);
    logic [31:0] product;
    if (shadow_div == '0) begin
      return 32'hFFFF_FFFF;
    end
    product = 32'(raw) * 32'(shadow_gain);
    return product / 32'(shadow_div);
  endfunction

  function automatic bit off_window(logic [READING_BITS-1:0] raw);
    logic [31:0] v;
    v = scale_value(raw);
    return (v < 32'(shadow_low) * 32'(LIMIT_SCALE)) || (v > 32'(shadow_high) * 32'(LIMIT_SCALE));
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_down(logic [COUNT_BITS-1:0] c);
    if (c != IDLE_MARK && c != '0) begin
      return c - COUNT_BITS'(1);
    end
    return c;
  endfunction

  function automatic int unsigned armed_count(bit for_mains);
    if (shadow_delay == UNSET_DELAY) begin
      return for_mains ? 32'(MAINS_UNSET_COUNT) : 32'(GEN_UNSET_COUNT);
    end
    return 32'(shadow_delay) * (for_mains ? 32'(MAINS_DELAY_SCALE) : 32'(GEN_DELAY_SCALE));
  endfunction

  task automatic predict_monitor(in_item_t item);
    bit        mains_bad;
    bit        gen_bad;
    out_item_t res;
    if (item.op == OP_TICK) begin
      mains_timer = count_down(mains_timer);
      gen_timer   = count_down(gen_timer);
      tick_count++;
    end else begin
      mains_bad = off_window(item.mains_reading_a) || off_window(item.mains_reading_b) ||
                  off_window(item.mains_reading_c);
      gen_bad   = off_window(item.generator_reading);
      if (mains_bad) begin
        if (mains_timer == IDLE_MARK) begin
          mains_timer = COUNT_BITS'(armed_count(1'b1));
        end
      end else begin
        mains_timer = IDLE_MARK;
      end
      if (gen_bad) begin
        if (gen_timer == IDLE_MARK) begin
          gen_timer = COUNT_BITS'(armed_count(1'b0));
        end
      end else begin
        gen_timer = IDLE_MARK;
      end
      if (mains_bad && gen_bad && mains_timer == '0 && gen_timer == '0) begin
        res.action = ACT_BOTH;
      end else if (mains_bad && mains_timer == '0) begin
        res.action = ACT_MAINS;
      end else if (gen_bad && gen_timer == '0) begin
        res.action = ACT_GEN;
      end else begin
        res.action = ACT_NONE;
      end
      res.mains_out_of_window     = mains_bad;
      res.generator_out_of_window = gen_bad;
      pending_results.push_back(res);
      sample_count++;
    end
  endtask

  task automatic send_item(in_item_t item);
    int gap;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_monitor(item);
    items_sent++;
  endtask

  task automatic wait_for_results(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_transfer(bit write, logic [2:0] idx, logic [DATA_BITS-1:0] wdata,
                              output logic [DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [DATA_BITS-1:0] shadow_of(logic [2:0] idx);
    case (idx)
      REG_GAIN:    return DATA_BITS'(shadow_gain);
      REG_DIVISOR: return DATA_BITS'(shadow_div);
      REG_LOW:     return DATA_BITS'(shadow_low);
      REG_HIGH:    return DATA_BITS'(shadow_high);
      REG_DELAY:   return DATA_BITS'(shadow_delay);
      default:     return '0;
    endcase
  endfunction

  task automatic check_register(logic [2:0] idx);
    logic [DATA_BITS-1:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== shadow_of(idx)) begin
      note_mismatch($sformatf("register %0d read %0h, expected %0h", idx, rd, shadow_of(idx)));
    end
  endtask

  task automatic set_register(logic [2:0] idx, int unsigned value);
    logic [DATA_BITS-1:0] rd;
    apb_transfer(1'b1, idx, DATA_BITS'(value), rd);
    case (idx)
      REG_GAIN:    shadow_gain  = GAIN_BITS'(value);
      REG_DIVISOR: shadow_div   = DIV_BITS'(value);
      REG_LOW:     shadow_low   = LIMIT_BITS'(value);
      REG_HIGH:    shadow_high  = LIMIT_BITS'(value);
      REG_DELAY:   shadow_delay = DELAY_BITS'(value);
      default: ;
    endcase
    check_register(idx);
  endtask

  task automatic apply_settings(int unsigned gain, int unsigned div, int unsigned low,
                                int unsigned high, int unsigned delay);
    set_register(REG_GAIN, gain);
    set_register(REG_DIVISOR, div);
    set_register(REG_LOW, low);
    set_register(REG_HIGH, high);
    set_register(REG_DELAY, delay);
  endtask

  function automatic logic [READING_BITS-1:0] edge_reading();
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    if (shadow_gain == '0 || shadow_div == '0) begin
      return READING_BITS'($urandom);
    end
    lo = (32'(shadow_low) * 32'(LIMIT_SCALE) * 32'(shadow_div) + 32'(shadow_gain) - 1) /
         32'(shadow_gain);
    hi = ((32'(shadow_high) * 32'(LIMIT_SCALE) + 1) * 32'(shadow_div) - 1) / 32'(shadow_gain);
    case ($urandom_range(0, 3))
      0:       r = lo - 1;
      1:       r = lo;
      2:       r = hi;
      default: r = hi + 1;
    endcase
    return (r > 32'({READING_BITS{1'b1}})) ? {READING_BITS{1'b1}} : READING_BITS'(r);
  endfunction

  function automatic logic [READING_BITS-1:0] any_reading();
    return ($urandom_range(0, 1) == 0) ? READING_BITS'($urandom) : edge_reading();
  endfunction

  function automatic logic [READING_BITS-1:0] pick_reading(bit want_bad);
    logic [READING_BITS-1:0] r;
    r = edge_reading();
    if ($urandom_range(0, 3) == 0 && off_window(r) == want_bad) begin
      return r;
    end
    for (int i = 0; i < 32; i++) begin
      r = READING_BITS'($urandom);
      if (off_window(r) == want_bad) begin
        return r;
      end
    end
    return r;
  endfunction

  function automatic in_item_t sample_of(logic [READING_BITS-1:0] g, logic [READING_BITS-1:0] a,
                                         logic [READING_BITS-1:0] b, logic [READING_BITS-1:0] c);
    in_item_t s;
    s.op                = OP_SAMPLE;
    s.generator_reading = g;
    s.mains_reading_a   = a;
    s.mains_reading_b   = b;
    s.mains_reading_c   = c;
    return s;
  endfunction

  function automatic in_item_t fault_sample(bit [3:0] pattern);
    return sample_of(pick_reading(pattern[3]), pick_reading(pattern[0]),
                     pick_reading(pattern[1]), pick_reading(pattern[2]));
  endfunction

  function automatic in_item_t noise_item(logic op);
    return '{op: op, generator_reading: any_reading(), mains_reading_a: any_reading(),
             mains_reading_b: any_reading(), mains_reading_c: any_reading()};
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %0h arrived with nothing outstanding", out_data));
      end else begin
        want = pending_results.pop_front();
        action_seen[want.action]++;
        if (out_data.action !== want.action ||
            out_data.mains_out_of_window !== want.mains_out_of_window ||
            out_data.generator_out_of_window !== want.generator_out_of_window) begin
          note_mismatch($sformatf("action %0d/%0d mains %0b/%0b generator %0b/%0b (got/exp)",
                                  out_data.action, want.action,
                                  out_data.mains_out_of_window, want.mains_out_of_window,
                                  out_data.generator_out_of_window,
                                  want.generator_out_of_window));
        end
      end
      rx_wait = pace_on ? $urandom_range(0, 3) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_reset_state();
    for (int i = 0; i <= 4; i++) begin
      check_register(3'(i));
    end
    send_item(sample_of(10'd0, 10'd0, 10'd0, 10'd0));
    send_item(sample_of(10'd1023, 10'd1023, 10'd1023, 10'd1023));
    send_item(noise_item(OP_TICK));
    send_item(noise_item(OP_SAMPLE));
    wait_for_results(SETTLE_CYCLES);
  endtask

  task automatic test_register_access();
    apply_settings(0, 0, 0, 0, 0);
    apply_settings(255, 65535, 240, 240, 255);
    apply_settings(255, 100, 100, 240, 0);
  endtask

  task automatic test_directed_windows();
    send_item(sample_of(10'd600, 10'd600, 10'd600, 10'd600));
    send_item(sample_of(10'd600, 10'd0, 10'd600, 10'd600));
    send_item(sample_of(10'd600, 10'd600, 10'd1023, 10'd600));
    send_item(sample_of(10'd600, 10'd600, 10'd600, 10'd1023));
    send_item(sample_of(10'd1023, 10'd600, 10'd600, 10'd600));
    send_item(sample_of(10'd0, 10'd1023, 10'd0, 10'd1023));
    send_item(noise_item(OP_TICK));
    send_item(sample_of(10'd0, 10'd0, 10'd0, 10'd0));
    wait_for_results(SETTLE_CYCLES);
    set_register(REG_DELAY, 1);
    send_item(sample_of(10'd600, 10'd600, 10'd600, 10'd600));
    send_item(sample_of(10'd1023, 10'd600, 10'd600, 10'd600));
    send_item(sample_of(10'd1023, 10'd0, 10'd600, 10'd600));
    wait_for_results(SETTLE_CYCLES);
    set_register(REG_DELAY, 255);
    send_item(sample_of(10'd600, 10'd600, 10'd600, 10'd600));
    send_item(sample_of(10'd0, 10'd0, 10'd0, 10'd0));
    wait_for_results(SETTLE_CYCLES);
    apply_settings(255, 0, 100, 240, 0);
    send_item(sample_of(10'd0, 10'd0, 10'd0, 10'd0));
    send_item(sample_of(10'd600, 10'd600, 10'd600, 10'd600));
    wait_for_results(SETTLE_CYCLES);
    apply_settings(255, 100, 240, 0, 0);
    send_item(sample_of(10'd600, 10'd600, 10'd600, 10'd600));
    wait_for_results(SETTLE_CYCLES);
    apply_settings(0, 65535, 0, 0, 0);
    send_item(sample_of(10'd1023, 10'd1023, 10'd1023, 10'd1023));
    wait_for_results(SETTLE_CYCLES);
    apply_settings(255, 65535, 0, 240, 0);
    send_item(sample_of(10'd1023, 10'd0, 10'd512, 10'd1023));
    wait_for_results(SETTLE_CYCLES);
  endtask

  task automatic test_backpressure();
    apply_settings(255, 100, 100, 240, 1);
    pace_on = 1'b0;
    rx_hold = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) begin
      send_item(fault_sample(4'($urandom)));
      send_item(noise_item(OP_TICK));
    end
    wait_for_results(0);
    for (int i = 0; i < 4; i++) begin
      send_item(fault_sample(4'($urandom)));
    end
    pace_on = 1'b1;
    wait_for_results(SETTLE_CYCLES);
  endtask

  task automatic random_settings();
    int unsigned gain;
    int unsigned div;
    int unsigned low;
    int unsigned high;
    int unsigned delay;
    if ($urandom_range(0, 9) == 0) begin
      gain  = $urandom_range(0, 1) ? 255 : 0;
      case ($urandom_range(0, 2))
        0:       div = 0;
        1:       div = 65535;
        default: div = 1;
      endcase
      low   = $urandom_range(0, 1) ? 240 : 0;
      high  = $urandom_range(0, 1) ? 240 : 0;
      case ($urandom_range(0, 2))
        0:       delay = 0;
        1:       delay = 254;
        default: delay = 255;
      endcase
    end else begin
      gain  = $urandom_range(150, 255);
      div   = $urandom_range(40, 160);
      low   = $urandom_range(20, 110);
      high  = $urandom_range(130, 240);
      delay = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 2);
    end
    apply_settings(gain, div, low, high, delay);
  endtask

  task automatic test_random_traffic();
    int       goal;
    int       kind;
    int       n;
    int       target;
    bit [3:0] pattern;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      random_settings();
      pace_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(4, 10)) begin
        if (items_sent >= goal) begin
          break;
        end
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          send_item(fault_sample(4'b0000));
          pattern = 4'($urandom_range(1, 15));
          send_item(fault_sample(pattern));
          if (pattern[3] && (pattern[2:0] == 3'b000 || $urandom_range(0, 1) == 1)) begin
            target = armed_count(1'b0);
          end else begin
            target = armed_count(1'b1);
          end
          if (target > 600) begin
            n = $urandom_range(0, 20);
          end else begin
            n = target + $urandom_range(0, 2) - 1;
          end
          if (n < 0) begin
            n = 0;
          end
          repeat (n) send_item(noise_item(OP_TICK));
          repeat ($urandom_range(1, 3)) send_item(fault_sample(4'($urandom)));
        end else if (kind == 7) begin
          repeat ($urandom_range(1, 4)) send_item(noise_item(1'($urandom)));
        end else if (kind == 8) begin
          send_item(fault_sample(4'($urandom_range(1, 15))));
          repeat ($urandom_range(0, 5)) send_item(noise_item(OP_TICK));
          send_item(fault_sample(4'b0000));
          send_item(fault_sample(4'($urandom_range(1, 15))));
        end else begin
          wait_for_results(0);
        end
      end
      wait_for_results(SETTLE_CYCLES);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_access();
    test_directed_windows();
    test_backpressure();
    test_random_traffic();
    wait_for_results(SETTLE_CYCLES);
    $display("checked %0d results from %0d samples and %0d ticks over random settings",
             results_seen, sample_count, tick_count);
    $display("actions: both %0d, mains %0d, generator %0d, none %0d; mismatches %0d",
             action_seen[ACT_BOTH], action_seen[ACT_MAINS], action_seen[ACT_GEN],
             action_seen[ACT_NONE], mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mains_generator_voltage_fault_monitor.f =====
rtl/core/mgvfm_pkg.sv
rtl/core/mains_generator_voltage_fault_monitor.sv
rtl/core/mgvfm_checker.sv
tb/sv/mains_generator_voltage_fault_monitor_tb.sv
